>>> hw/rtl/bfec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfec_pkg
// Shared types and constants of the bit/frame error counter: item structs,
// register indexes and the lane geometry.
// ----------------------------------------------------------------------------
package bfec_pkg;

	localparam int DEF_MAX_FRAME_BITS = 65536;
	localparam int DEF_WORD_BITS      = 64;

	localparam int IN_WORD_W  = 64;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam int FRAME_BITS_W = 17;
	localparam int LIMIT_W      = 32;
	localparam int FEB_W        = 17;
	localparam int BET_W        = 48;
	localparam int FET_W        = 40;
	localparam int FT_W         = 40;

	// each lane checks one byte of the word
	localparam int LANE_BITS  = 8;
	localparam int LANE_CNT_W = $clog2(LANE_BITS + 1);

	localparam logic [FRAME_BITS_W-1:0] FRAME_BITS_RST = FRAME_BITS_W'(1024);

	typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_BITS       = 2'd0,
		REG_MAX_FRAME_ERRORS = 2'd1,
		REG_MAX_FRAMES       = 2'd2
	} bfec_reg_e;

	typedef struct packed {
		logic [IN_WORD_W-1:0] ref_word;
		logic [IN_WORD_W-1:0] dec_word;
	} bfec_word_t;

	typedef struct packed {
		logic [FT_W-1:0]  frame_count;
		logic [FEB_W-1:0] frame_bit_errors;
		logic             frame_error;
		logic [BET_W-1:0] total_bit_errors;
		logic [FET_W-1:0] total_frame_errors;
		logic             error_limit_reached;
		logic             frame_limit_reached;
		logic             measurement_done;
	} bfec_result_t;

	// handoff from the lane stage to the merge stage
	typedef struct packed {
		logic consume;
		logic last;
	} bfec_ctl_t;

endpackage

>>> hw/rtl/bit_frame_error_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_frame_error_counter_core
// Counts mismatching bits between reference and decoded words, frame by
// frame, and reports per-frame errors, saturating totals and limit flags.
// ----------------------------------------------------------------------------
//  channel | signals                           | direction | moves
//  word    | word_valid, word_ready, word      | in        | one word of both streams
//  result  | result_valid, result_ready, result| out       | one item per finished frame
//  cfg     | cfg_valid, cfg_ready, cfg_index,  | in        | register write
//          | cfg_data                          |           |
//
//  one word accepted per cycle while word_ready is high; a frame's result passes
//  through the lane stage, the merge stage and the output register, in that order
//  lane popcounts and the merge adder are each registered; totals saturate
//  reset clears all counters and sets the frame length to 1024 bits
//  a stalled result backs up through the result stage and lane stage before
//  word_ready drops; words that end no frame never wait on the output
// ----------------------------------------------------------------------------
module bit_frame_error_counter_core #(
	parameter int MAX_FRAME_BITS = bfec_pkg::DEF_MAX_FRAME_BITS,
	parameter int WORD_BITS      = bfec_pkg::DEF_WORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   word_valid,
	output logic                   word_ready,
	input  bfec_pkg::bfec_word_t   word,
	output logic                   result_valid,
	input  logic                   result_ready,
	output bfec_pkg::bfec_result_t result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  bfec_pkg::cfg_index_t   cfg_index,
	input  bfec_pkg::cfg_data_t    cfg_data
);
	import bfec_pkg::*;

	localparam int LEN_W   = ($clog2(MAX_FRAME_BITS + 1) > FRAME_BITS_W) ?
		$clog2(MAX_FRAME_BITS + 1) : FRAME_BITS_W;
	localparam int BP_W    = $clog2(MAX_FRAME_BITS + 1);
	localparam int TAKE_W  = $clog2(WORD_BITS + 1);
	localparam int N_LANES = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
	localparam int PAD_W   = N_LANES * LANE_BITS;

	// configuration
	logic [FRAME_BITS_W-1:0] frame_bits_q;
	logic [LIMIT_W-1:0]      max_frame_errors_q;
	logic [LIMIT_W-1:0]      max_frames_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bits_q       <= FRAME_BITS_RST;
			max_frame_errors_q <= '0;
			max_frames_q       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_BITS:       frame_bits_q       <= cfg_data[FRAME_BITS_W-1:0];
				REG_MAX_FRAME_ERRORS: max_frame_errors_q <= cfg_data[LIMIT_W-1:0];
				REG_MAX_FRAMES:       max_frames_q       <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// frame position and bits taken from this word
	logic [BP_W-1:0]   bp_q;
	logic [LEN_W-1:0]  fb_ext;
	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  bp_ext;
	logic [LEN_W-1:0]  rem;
	logic [TAKE_W-1:0] take;
	logic              last;
	logic              accept;

	always_comb begin
		fb_ext = LEN_W'(frame_bits_q);
		if (fb_ext == '0) begin
			len = LEN_W'(1);
		end else if (fb_ext > LEN_W'(MAX_FRAME_BITS)) begin
			len = LEN_W'(MAX_FRAME_BITS);
		end else begin
			len = fb_ext;
		end
		bp_ext = LEN_W'(bp_q);
		rem    = len - bp_ext;
		// length shrunk to or below the position: word counts nothing and ends the frame
		if (bp_ext >= len) begin
			take = '0;
			last = 1'b1;
		end else if (rem <= LEN_W'(WORD_BITS)) begin
			take = rem[TAKE_W-1:0];
			last = 1'b1;
		end else begin
			take = TAKE_W'(WORD_BITS);
			last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q <= '0;
		end else if (accept) begin
			bp_q <= last ? '0 : bp_q + BP_W'(WORD_BITS);
		end
	end

	// lanes
	logic [IN_WORD_W-1:0]                  word_diff;
	logic [PAD_W-1:0]                      diff_pad;
	logic [N_LANES-1:0][LANE_CNT_W-1:0]    lane_cnt_s1;

	assign word_diff = word.ref_word ^ word.dec_word;
	assign diff_pad  = PAD_W'(word_diff[WORD_BITS-1:0]);

	for (genvar l = 0; l < N_LANES; l++) begin : g_lane
		bfec_lane #(
			.BASE      (l * LANE_BITS),
			.WORD_BITS (WORD_BITS),
			.TAKE_W    (TAKE_W)
		) u_lane (
			.clk    (clk),
			.load   (accept),
			.diff   (diff_pad[l*LANE_BITS +: LANE_BITS]),
			.take   (take),
			.cnt_s1 (lane_cnt_s1[l])
		);
	end

	// stage handshake
	logic         vld_s1;
	logic         last_s1;
	logic         vld_s2;
	logic         out_load;
	logic         s1_take;
	bfec_ctl_t    ctl;
	bfec_result_t res_s2;
	bfec_result_t result_q;
	logic         result_valid_q;

	assign out_load   = vld_s2 && (!result_valid_q || result_ready);
	assign s1_take    = vld_s1 && (!last_s1 || !vld_s2 || out_load);
	assign word_ready = !vld_s1 || s1_take;
	assign accept     = word_valid && word_ready;
	assign ctl        = '{consume: s1_take, last: last_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_take) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last;
		end
	end

	bfec_merge #(
		.N_LANES (N_LANES)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.lane_cnt (lane_cnt_s1),
		.out_load (out_load),
		.vld_s2   (vld_s2),
		.res_s2   (res_s2)
	);

	// output register with limit flags
	logic         fe_lim;
	logic         fr_lim;
	bfec_result_t result_d;

	assign fe_lim = (max_frame_errors_q != '0) &&
		(res_s2.total_frame_errors >= FET_W'(max_frame_errors_q));
	assign fr_lim = (max_frames_q != '0) &&
		(res_s2.frame_count >= FT_W'(max_frames_q));

	always_comb begin
		result_d                     = res_s2;
		result_d.error_limit_reached = fe_lim;
		result_d.frame_limit_reached = fr_lim;
		result_d.measurement_done    = fe_lim || fr_lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> hw/rtl/bfec_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfec_lane
// One error-count lane: masks its slice of the mismatch word against the
// number of bits still in the frame and registers the popcount.
// ----------------------------------------------------------------------------
module bfec_lane #(
	parameter int BASE      = 0,
	parameter int WORD_BITS = bfec_pkg::DEF_WORD_BITS,
	parameter int TAKE_W    = $clog2(bfec_pkg::DEF_WORD_BITS + 1)
) (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic [bfec_pkg::LANE_BITS-1:0]       diff,
	input  logic [TAKE_W-1:0]                    take,
	output logic [bfec_pkg::LANE_CNT_W-1:0]      cnt_s1
);
	import bfec_pkg::*;

	logic [LANE_CNT_W-1:0] cnt;

	always_comb begin
		cnt = '0;
		for (int j = 0; j < LANE_BITS; j++) begin
			if ((BASE + j) < WORD_BITS && (BASE + j) < int'(take) && diff[j]) begin
				cnt = cnt + LANE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_s1 <= cnt;
		end
	end

endmodule

>>> hw/rtl/bfec_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfec_merge
// Merge stage: adds the lane counts into the frame error count and, at the
// end of a frame, updates the saturating totals and loads the result stage.
// ----------------------------------------------------------------------------
module bfec_merge #(
	parameter int N_LANES = 8
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  bfec_pkg::bfec_ctl_t                                ctl,
	input  logic [N_LANES-1:0][bfec_pkg::LANE_CNT_W-1:0]       lane_cnt,
	input  logic                                               out_load,
	output logic                                               vld_s2,
	output bfec_pkg::bfec_result_t                             res_s2
);
	import bfec_pkg::*;

	localparam int SUM_W = $clog2(N_LANES * LANE_BITS + 1);

	logic [SUM_W-1:0] sum;
	logic [FEB_W:0]   errs_sum;
	logic [FEB_W-1:0] errs;
	logic [BET_W:0]   bet_sum;
	logic [BET_W-1:0] bet_nx;
	logic [FET_W-1:0] fet_nx;
	logic [FT_W-1:0]  ft_nx;

	logic [FEB_W-1:0] feb_q;
	logic [BET_W-1:0] bet_q;
	logic [FET_W-1:0] fet_q;
	logic [FT_W-1:0]  ft_q;

	always_comb begin
		sum = '0;
		for (int l = 0; l < N_LANES; l++) begin
			sum = sum + SUM_W'(lane_cnt[l]);
		end
		errs_sum = {1'b0, feb_q} + (FEB_W + 1)'(sum);
		errs     = errs_sum[FEB_W] ? '1 : errs_sum[FEB_W-1:0];

		bet_sum = {1'b0, bet_q} + (BET_W + 1)'(errs);
		bet_nx  = bet_sum[BET_W] ? '1 : bet_sum[BET_W-1:0];
		fet_nx  = (errs != '0 && fet_q != '1) ? fet_q + FET_W'(1) : fet_q;
		ft_nx   = (ft_q != '1) ? ft_q + FT_W'(1) : ft_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feb_q  <= '0;
			bet_q  <= '0;
			fet_q  <= '0;
			ft_q   <= '0;
			vld_s2 <= 1'b0;
		end else begin
			if (ctl.consume) begin
				if (ctl.last) begin
					feb_q <= '0;
					bet_q <= bet_nx;
					fet_q <= fet_nx;
					ft_q  <= ft_nx;
				end else begin
					feb_q <= errs;
				end
			end
			if (ctl.consume && ctl.last) begin
				vld_s2 <= 1'b1;
			end else if (out_load) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// limit flags are filled in at the output register
	always_ff @(posedge clk) begin
		if (ctl.consume && ctl.last) begin
			res_s2.frame_count         <= ft_nx;
			res_s2.frame_bit_errors    <= errs;
			res_s2.frame_error         <= (errs != '0);
			res_s2.total_bit_errors    <= bet_nx;
			res_s2.total_frame_errors  <= fet_nx;
			res_s2.error_limit_reached <= 1'b0;
			res_s2.frame_limit_reached <= 1'b0;
			res_s2.measurement_done    <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/bfec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfec_checker
// Port-level checks of the error counter's result channel.
// ----------------------------------------------------------------------------
module bfec_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_ready,
	input bfec_pkg::bfec_result_t result
);
	import bfec_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_ferr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.frame_error == (result.frame_bit_errors != '0))
		else $error("frame error flag disagrees with bit errors");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.measurement_done ==
			(result.error_limit_reached || result.frame_limit_reached))
		else $error("done flag disagrees with limit flags");

	a_tot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.frame_count != '0 &&
			result.total_frame_errors <= result.frame_count)
		else $error("frame totals inconsistent");

	a_bet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_error |-> result.total_bit_errors != '0 &&
			result.total_frame_errors != '0)
		else $error("errored frame missing from totals");

endmodule

bind bit_frame_error_counter_core bfec_checker u_bfec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bit/frame error counter. Word pairs with
// controlled error patterns are pushed through the core. A tracker class keeps
// its own copy of the frame position, the counters and the registers, and
// works out each frame's result when the word that closes the frame is
// accepted. Results are compared field by field in order. The sender works in
// bursts, the result side stalls on its own pattern, and the registers are
// rewritten between phases, also while a frame is only partly done.
// ----------------------------------------------------------------------------
import bfec_pkg::*;

class frame_error_tracker;
	bfec_result_t            frames_due[$];
	logic [FRAME_BITS_W-1:0] frame_bits;
	logic [LIMIT_W-1:0]      max_frame_errors;
	logic [LIMIT_W-1:0]      max_frames;
	int unsigned             bit_pos;
	int unsigned             frame_errs;
	logic [BET_W-1:0]        bit_err_total;
	logic [FET_W-1:0]        frame_err_total;
	logic [FT_W-1:0]         frame_total;
	int unsigned             words_seen;
	int unsigned             frames_seen;
	int unsigned             bad_frames_seen;
	int unsigned             done_frames_seen;
	int unsigned             mismatches;

	function new();
		frame_bits = FRAME_BITS_RST;
		max_frame_errors = '0;
		max_frames = '0;
		bit_pos = 0;
		frame_errs = 0;
		bit_err_total = '0;
		frame_err_total = '0;
		frame_total = '0;
		words_seen = 0;
		frames_seen = 0;
		bad_frames_seen = 0;
		done_frames_seen = 0;
		mismatches = 0;
	endfunction

	function void write_reg(cfg_index_t idx, cfg_data_t data);
		case (idx)
			REG_FRAME_BITS:       frame_bits = data[FRAME_BITS_W-1:0];
			REG_MAX_FRAME_ERRORS: max_frame_errors = data;
			REG_MAX_FRAMES:       max_frames = data;
			default: ; // unused index, write dropped
		endcase
	endfunction

	function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] top);
		if (a >= top || b >= top - a)
			return top;
		return a + b;
	endfunction

	function void note_word(bfec_word_t w);
		int unsigned  len;
		int unsigned  take;
		int unsigned  errs;
		bit           closes;
		bit           err_lim;
		bit           frm_lim;
		logic [63:0]  live;
		bfec_result_t want;
		words_seen++;
		len = 32'(frame_bits);
		if (len == 0)
			len = 1;
		if (len > DEF_MAX_FRAME_BITS)
			len = DEF_MAX_FRAME_BITS;
		// position past a shrunk length: word adds nothing and closes the frame
		if (bit_pos >= len) begin
			take = 0;
			closes = 1'b1;
		end else if (len - bit_pos <= DEF_WORD_BITS) begin
			take = len - bit_pos;
			closes = 1'b1;
		end else begin
			take = DEF_WORD_BITS;
			closes = 1'b0;
		end
		live = (take >= 64) ? '1 : ((64'd1 << take) - 64'd1);
		errs = frame_errs + $countones((w.ref_word ^ w.dec_word) & live);
		if (errs > (1 << FEB_W) - 1)
			errs = (1 << FEB_W) - 1;
		if (!closes) begin
			bit_pos += take;
			frame_errs = errs;
		end else begin
			bit_pos = 0;
			frame_errs = 0;
			if (errs != 0) begin
				bit_err_total = BET_W'(add_sat(64'(bit_err_total), 64'(errs),
					64'({BET_W{1'b1}})));
				frame_err_total = FET_W'(add_sat(64'(frame_err_total), 64'd1,
					64'({FET_W{1'b1}})));
			end
			frame_total = FT_W'(add_sat(64'(frame_total), 64'd1, 64'({FT_W{1'b1}})));
			err_lim = (max_frame_errors != 0) && (frame_err_total >= max_frame_errors);
			frm_lim = (max_frames != 0) && (frame_total >= max_frames);
			want.frame_count = frame_total;
			want.frame_bit_errors = errs[FEB_W-1:0];
			want.frame_error = (errs != 0);
			want.total_bit_errors = bit_err_total;
			want.total_frame_errors = frame_err_total;
			want.error_limit_reached = err_lim;
			want.frame_limit_reached = frm_lim;
			want.measurement_done = err_lim || frm_lim;
			frames_due.push_back(want);
		end
	endfunction

	task report(string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report($sformatf("frame %0d %s: got 0x%0h, expected 0x%0h",
				frames_seen, name, got, want));
	endtask

	task check_frame(bfec_result_t got);
		bfec_result_t want;
		if (frames_due.size() == 0) begin
			report($sformatf("result with no frame due, frame_count %0d", got.frame_count));
		end else begin
			want = frames_due.pop_front();
			frames_seen++;
			if (want.frame_error)
				bad_frames_seen++;
			if (want.measurement_done)
				done_frames_seen++;
			check_field("frame_count", got.frame_count, want.frame_count);
			check_field("frame_bit_errors", got.frame_bit_errors, want.frame_bit_errors);
			check_field("frame_error", got.frame_error, want.frame_error);
			check_field("total_bit_errors", got.total_bit_errors, want.total_bit_errors);
			check_field("total_frame_errors", got.total_frame_errors,
				want.total_frame_errors);
			check_field("error_limit_reached", got.error_limit_reached,
				want.error_limit_reached);
			check_field("frame_limit_reached", got.frame_limit_reached,
				want.frame_limit_reached);
			check_field("measurement_done", got.measurement_done, want.measurement_done);
		end
	endtask
endclass

module testbench;
	localparam cfg_index_t REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES        = 10;
	localparam int PHASE_WORDS   = 113;
	localparam int HOLD_PHASE    = 0;
	localparam int PAUSE_PHASE   = 4;

	logic         clk;
	logic         arst_n;
	logic         word_valid;
	logic         word_ready;
	bfec_word_t   word;
	logic         result_valid;
	logic         result_ready;
	bfec_result_t result;
	logic         cfg_valid;
	logic         cfg_ready;
	cfg_index_t   cfg_index;
	cfg_data_t    cfg_data;
	bit           hold_request;

	frame_error_tracker tracker;

	bit_frame_error_counter_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word(word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// result check first: an item accepted on this edge cannot close until later
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				tracker.check_frame(result);
			if (word_valid && word_ready)
				tracker.note_word(word);
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
		end
	end

	initial begin : result_sink
		int unsigned mode, stretch, hold_left;
		mode = 0;
		stretch = 0;
		hold_left = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 3);
					stretch = $urandom_range(4, 80);
				end
				stretch--;
				case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= ($urandom_range(0, 1) == 1);
					2: result_ready <= ($urandom_range(0, 7) != 0);
					default: result_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bfec_word_t word_of(logic [63:0] r, logic [63:0] d);
		bfec_word_t w;
		w.ref_word = r;
		w.dec_word = d;
		return w;
	endfunction

	function automatic bfec_word_t make_word(int unsigned clean_pct);
		logic [63:0] base, flips;
		base = rand64();
		if ($urandom_range(0, 99) < clean_pct)
			flips = '0;
		else begin
			case ($urandom_range(0, 5))
				0: flips = 64'd1 << $urandom_range(0, 63);
				1, 2: flips = rand64() & rand64() & rand64();
				3: flips = '1;
				default: flips = rand64();
			endcase
		end
		return word_of(base, base ^ flips);
	endfunction

	function automatic cfg_data_t pick_limit(logic [FT_W-1:0] so_far);
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 1;
			2: return '1;
			3: return $urandom;
			default: return so_far[LIMIT_W-1:0] + $urandom_range(1, 25);
		endcase
	endfunction

	// valid stays high on return so the next item can follow back to back
	task automatic offer_word(input bfec_word_t w);
		word_valid <= 1'b1;
		word <= w;
		do @(posedge clk); while (!word_ready);
		@(negedge clk);
	endtask

	task automatic idle_words(input int unsigned cycles);
		word_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		word_valid <= 1'b0;
		while (tracker.frames_due.size() != 0)
			@(negedge clk);
		// a word that closes no frame may still be in the lanes
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input cfg_index_t idx, input cfg_data_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned phase, n, burst_left, gap, clean_pct;
		bit          steady;
		cfg_data_t   fb;
		tracker = new();
		arst_n = 1'b0;
		word_valid = 1'b0;
		word = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_request = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		// default 1024-bit frame, left open after two words
		offer_word(word_of('0, '0));
		offer_word(word_of('1, '0));
		drain();
		// zero length acts as one bit; the open frame closes with no new bits
		set_reg(REG_FRAME_BITS, 0);
		offer_word(word_of(rand64(), rand64()));
		offer_word(word_of(64'h1, '0));
		offer_word(word_of(~64'h1, '0));
		offer_word(word_of('0, '1));
		drain();
		set_reg(REG_FRAME_BITS, 64);
		set_reg(REG_MAX_FRAME_ERRORS, 3);
		set_reg(REG_MAX_FRAMES, '1);
		offer_word(word_of('1, '0));
		offer_word(word_of(64'hA5A5_5A5A_F00F_0FF0, 64'hA5A5_5A5A_F00F_0FF0));
		drain();
		// one bit spills into a second word, the rest of it is masked
		set_reg(REG_FRAME_BITS, 65);
		set_reg(REG_MAX_FRAMES, 9);
		fb = $urandom;
		offer_word(word_of({fb, fb}, ~{fb, fb}));
		offer_word(word_of(64'h2, '0));
		offer_word(word_of('0, 64'h8000_0000_0000_0001));
		offer_word(word_of(64'h1, '0));
		offer_word(word_of('0, '0));
		offer_word(word_of('0, '0));
		drain();
		// length above the cap, then shrunk to end two bits into the third word
		set_reg(REG_FRAME_BITS, 131071);
		set_reg(REG_MAX_FRAME_ERRORS, 0);
		set_reg(REG_MAX_FRAMES, 0);
		set_reg(REG_UNUSED, '1);
		offer_word(word_of(rand64(), rand64()));
		offer_word(word_of(rand64(), rand64()));
		drain();
		set_reg(REG_FRAME_BITS, 130);
		offer_word(word_of(rand64(), rand64()));
		drain();
		// bits above the 17-bit field are dropped, leaving 64
		set_reg(REG_FRAME_BITS, 32'h0002_0040);
		offer_word(word_of(rand64(), rand64()));
		drain();

		burst_left = 0;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: fb = 1;
				1: fb = 64;
				2: fb = 65;
				3: fb = 127;
				4: fb = $urandom_range(1, 300);
				5: fb = 0;
				6: fb = 32'h0002_0000 | $urandom_range(1, 200);
				7: fb = 131071;
				8: fb = $urandom_range(1, 64);
				default: fb = $urandom_range(100, 600);
			endcase
			set_reg(REG_FRAME_BITS, fb);
			if ($urandom_range(0, 2) != 0)
				set_reg(REG_MAX_FRAME_ERRORS, pick_limit(tracker.frame_err_total));
			if ($urandom_range(0, 2) != 0)
				set_reg(REG_MAX_FRAMES, pick_limit(tracker.frame_total));
			if ($urandom_range(0, 3) == 0)
				set_reg(REG_UNUSED, $urandom);
			clean_pct = $urandom_range(0, 3) * 33;
			steady = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_WORDS; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					if (!steady && gap != 0 && n != 0)
						idle_words(gap);
				end
				burst_left--;
				// one-bit frames: every item is a result, so the long hold backs up
				if (phase == HOLD_PHASE && n == 10)
					hold_request = 1'b1;
				if (phase == PAUSE_PHASE && n == PHASE_WORDS / 2)
					drain();
				offer_word(make_word(clean_pct));
			end
			drain();
		end

		$display("%0d words sent, %0d frames checked, %0d with bit errors, %0d past a limit",
			tracker.words_seen, tracker.frames_seen, tracker.bad_frames_seen,
			tracker.done_frames_seen);
		$display("frame lengths from one bit to the cap, shrinks mid frame, limits off to max");
		if (tracker.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
